// ===== rtl/core/stillness_gated_accel_bias_tracker_core_macros.svh =====
`ifndef STILLNESS_GATED_ACCEL_BIAS_TRACKER_CORE_MACROS_SVH
`define STILLNESS_GATED_ACCEL_BIAS_TRACKER_CORE_MACROS_SVH

// same-cycle implication, off while reset is held
`define SGABT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SGABT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sgabt_pkg.sv =====
package sgabt_pkg;

    // item field widths
    localparam int ACCEL_W = 20;
    localparam int RATE_W  = 20;
    localparam int QUAT_W  = 16;
    localparam int OUT_W   = 22;

    // configuration registers
    localparam int TICKS_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int GRAV_W     = 15;
    localparam int TOL_W      = 14;
    localparam int GYRO_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICKS_W-1:0] TICKS_RST = TICKS_W'(200);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(9830);
    localparam logic [GRAV_W-1:0]  GRAV_RST  = GRAV_W'(10042);
    localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(512);
    localparam logic [GYRO_W-1:0]  GYRO_RST  = GYRO_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS = 3'd0,
        CFG_GAIN  = 3'd1,
        CFG_GRAV  = 3'd2,
        CFG_TOL   = 3'd3,
        CFG_GYRO  = 3'd4
    } t_cfg_idx;

    // still counter
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // shared multiplier and datapath widths
    localparam int MUL_A_W  = 35;
    localparam int MUL_B_W  = 23;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int COEF_W   = 33;
    localparam int MAG_W    = 40;
    localparam int LIM_W    = 18;
    localparam int EARTH_W  = 55;
    localparam int EARTH_SH = 28;
    localparam int SAMP_W   = EARTH_W + 1 - EARTH_SH;
    localparam int DIFF_W   = OUT_W + 1;
    localparam int NUDGE_W  = 40;
    localparam int GAIN_SH  = 16;
    localparam int SAT_IN_W = 32;

    localparam logic signed [EARTH_W:0] EARTH_HALF = (EARTH_W + 1)'(1) <<< (EARTH_SH - 1);
    localparam logic signed [NUDGE_W:0] NUDGE_HALF = (NUDGE_W + 1)'(1) <<< (GAIN_SH - 1);
    localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

endpackage

// ===== rtl/core/sgabt_in_if.sv =====
interface sgabt_in_if
    import sgabt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;
    logic signed [RATE_W-1:0]  rate_z;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
               quat_w, quat_x, quat_y, quat_z,
        input  ready
    );

    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
               quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

// ===== rtl/core/sgabt_out_if.sv =====
interface sgabt_out_if
    import sgabt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] vertical_accel;
    logic signed [OUT_W-1:0] bias_now;
    logic                    bias_valid_flag;
    logic                    still_flag;

    modport source (
        output valid, vertical_accel, bias_now, bias_valid_flag, still_flag,
        input  ready
    );

    modport sink (
        input  valid, vertical_accel, bias_now, bias_valid_flag, still_flag,
        output ready
    );
endinterface

// ===== rtl/core/stillness_gated_accel_bias_tracker_core.sv =====
// Vertical acceleration with a stillness-gated bias tracker. Each input item (body accel,
// gyro rates, Q1.14 attitude quaternion) gives exactly one result item: the earth-vertical
// accel minus gravity minus the bias held before the item, the bias after the item, a
// bias-valid flag and the stillness verdict. All arithmetic runs through one signed
// 35x23 multiplier, registered at its output, stepped by a 21-step sequencer: three accel
// squares, three gyro squares, the three threshold squares, eight quaternion products, the
// three rotation terms, and one gain product for a bias nudge. Input ready is high only
// while the block is idle, so a new item is not taken before the last one is through; the
// result sits in an output register, so a stalled sink holds the block only at its last
// step. Configuration writes land at once and are meant for idle periods.
`include "stillness_gated_accel_bias_tracker_core_macros.svh"

module stillness_gated_accel_bias_tracker_core
    import sgabt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sgabt_in_if.sink              i_in,
    sgabt_out_if.source           o_res
);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_WAIT,
        S_ROUND,
        S_DECIDE,
        S_NMUL,
        S_NWAIT,
        S_NADD,
        S_OUT
    } t_state;

    // multiplier steps, in issue order
    typedef enum logic [4:0] {
        ST_AXX, ST_AYY, ST_AZZ,
        ST_GXX, ST_GYY, ST_GZZ,
        ST_LO, ST_HI, ST_GYRO,
        ST_QWW, ST_QXX, ST_QYY, ST_QZZ,
        ST_QWX, ST_QYZ, ST_QWY, ST_QXZ,
        ST_C0Z, ST_C1X, ST_C2Y,
        ST_NUDGE
    } t_step;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[OUT_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // control state
    t_state             r_state;
    t_step              r_step;
    logic               r_pvld;
    logic               r_ovalid;
    logic [TICKS_W-1:0] r_ticks;
    logic [GAIN_W-1:0]  r_gain;
    logic [GRAV_W-1:0]  r_grav;
    logic [TOL_W-1:0]   r_tol;
    logic [GYRO_W-1:0]  r_gyro;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [OUT_W-1:0] r_bias;
    logic               r_bias_vld;
    logic               r_nudged;

    // captured item
    logic signed [ACCEL_W-1:0] r_ax, r_ay, r_az;
    logic signed [RATE_W-1:0]  r_gx, r_gy, r_gz;
    logic signed [QUAT_W-1:0]  r_qw, r_qx, r_qy, r_qz;

    // datapath
    logic signed [PROD_W-1:0]  r_prod;
    t_step                     r_pstep;
    logic [MAG_W-1:0]          r_am, r_gm;
    logic                      r_lo_ok, r_hi_ok, r_gy_ok;
    logic signed [COEF_W-1:0]  r_c0, r_c1, r_c2;
    logic signed [EARTH_W-1:0] r_earth;
    logic signed [SAMP_W-1:0]  r_sample;
    logic signed [OUT_W-1:0]   r_vert;
    logic signed [DIFF_W-1:0]  r_d;
    logic                      r_still;
    logic signed [NUDGE_W-1:0] r_nudge;

    // output register
    logic signed [OUT_W-1:0] r_o_vert;
    logic signed [OUT_W-1:0] r_o_bias;
    logic                    r_o_bvld;
    logic                    r_o_still;

    logic                      in_acc;
    logic                      out_load;
    logic                      issue;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [LIM_W-1:0]   lim_lo, lim_hi, lim_gyro;
    logic signed [EARTH_W:0]   earth_b;
    logic signed [SAMP_W-1:0]  n_sample;
    logic signed [OUT_W-1:0]   dec_s;
    logic signed [OUT_W-1:0]   dec_vert;
    logic signed [DIFF_W-1:0]  dec_d;
    logic                      dec_still;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      dec_update;
    logic signed [NUDGE_W:0]   nudge_b;
    logic signed [NUDGE_W-GAIN_SH:0] nudge_step;
    logic signed [OUT_W-1:0]   n_bias;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_res.ready);
    assign issue    = (r_state == S_MUL) || (r_state == S_NMUL);

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_res.valid           = r_ovalid;
    assign o_res.vertical_accel  = r_o_vert;
    assign o_res.bias_now        = r_o_bias;
    assign o_res.bias_valid_flag = r_o_bvld;
    assign o_res.still_flag      = r_o_still;

    // magnitude bounds: gravity minus / plus tolerance, and the gyro limit
    assign lim_lo   = $signed(LIM_W'(r_grav)) - $signed(LIM_W'(r_tol));
    assign lim_hi   = $signed(LIM_W'(r_grav)) + $signed(LIM_W'(r_tol));
    assign lim_gyro = $signed(LIM_W'(r_gyro));

    // shared multiplier operand select
    always_comb begin
        case (r_step)
            ST_AXX:   begin mul_a = MUL_A_W'(r_ax); mul_b = MUL_B_W'(r_ax); end
            ST_AYY:   begin mul_a = MUL_A_W'(r_ay); mul_b = MUL_B_W'(r_ay); end
            ST_AZZ:   begin mul_a = MUL_A_W'(r_az); mul_b = MUL_B_W'(r_az); end
            ST_GXX:   begin mul_a = MUL_A_W'(r_gx); mul_b = MUL_B_W'(r_gx); end
            ST_GYY:   begin mul_a = MUL_A_W'(r_gy); mul_b = MUL_B_W'(r_gy); end
            ST_GZZ:   begin mul_a = MUL_A_W'(r_gz); mul_b = MUL_B_W'(r_gz); end
            ST_LO:    begin mul_a = MUL_A_W'(lim_lo); mul_b = MUL_B_W'(lim_lo); end
            ST_HI:    begin mul_a = MUL_A_W'(lim_hi); mul_b = MUL_B_W'(lim_hi); end
            ST_GYRO:  begin mul_a = MUL_A_W'(lim_gyro); mul_b = MUL_B_W'(lim_gyro); end
            ST_QWW:   begin mul_a = MUL_A_W'(r_qw); mul_b = MUL_B_W'(r_qw); end
            ST_QXX:   begin mul_a = MUL_A_W'(r_qx); mul_b = MUL_B_W'(r_qx); end
            ST_QYY:   begin mul_a = MUL_A_W'(r_qy); mul_b = MUL_B_W'(r_qy); end
            ST_QZZ:   begin mul_a = MUL_A_W'(r_qz); mul_b = MUL_B_W'(r_qz); end
            ST_QWX:   begin mul_a = MUL_A_W'(r_qw); mul_b = MUL_B_W'(r_qx); end
            ST_QYZ:   begin mul_a = MUL_A_W'(r_qy); mul_b = MUL_B_W'(r_qz); end
            ST_QWY:   begin mul_a = MUL_A_W'(r_qw); mul_b = MUL_B_W'(r_qy); end
            ST_QXZ:   begin mul_a = MUL_A_W'(r_qx); mul_b = MUL_B_W'(r_qz); end
            ST_C0Z:   begin mul_a = MUL_A_W'(r_c0); mul_b = MUL_B_W'(r_az); end
            // c1 and c2 are held at half weight, doubled here
            ST_C1X:   begin
                mul_a = MUL_A_W'($signed({r_c1, 1'b0}));
                mul_b = MUL_B_W'(r_ax);
            end
            ST_C2Y:   begin
                mul_a = MUL_A_W'($signed({r_c2, 1'b0}));
                mul_b = MUL_B_W'(r_ay);
            end
            ST_NUDGE: begin
                mul_a = MUL_A_W'($signed({1'b0, r_gain}));
                mul_b = MUL_B_W'(r_d);
            end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round half up to 1/1024 units, then take gravity off
    assign earth_b  = (EARTH_W + 1)'(r_earth) + EARTH_HALF;
    assign n_sample = $signed(earth_b[EARTH_W:EARTH_SH]) - $signed(SAMP_W'(r_grav));

    // stillness verdict and bias decision, on the bias held before this item
    assign dec_s     = sat_out(SAT_IN_W'(r_sample));
    assign dec_vert  = sat_out(SAT_IN_W'(r_sample) - SAT_IN_W'(r_bias));
    assign dec_d     = DIFF_W'(dec_s) - DIFF_W'(r_bias);
    assign dec_still = r_lo_ok && r_hi_ok && r_gy_ok;
    assign cnt_inc   = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
    assign dec_update = dec_still && (cnt_inc > r_ticks) && !r_nudged;

    // low-pass nudge: bias + round(gain * d / 2^16)
    assign nudge_b    = (NUDGE_W + 1)'(r_nudge) + NUDGE_HALF;
    assign nudge_step = $signed(nudge_b[NUDGE_W:GAIN_SH]);
    assign n_bias     = sat_out(SAT_IN_W'(r_bias) + SAT_IN_W'(nudge_step));

    // control: sequencer, tracker state, configuration, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= ST_AXX;
            r_pvld     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_ticks    <= TICKS_RST;
            r_gain     <= GAIN_RST;
            r_grav     <= GRAV_RST;
            r_tol      <= TOL_RST;
            r_gyro     <= GYRO_RST;
            r_cnt      <= '0;
            r_bias     <= '0;
            r_bias_vld <= 1'b0;
            r_nudged   <= 1'b0;
        end else begin
            r_pvld <= issue;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TICKS: r_ticks <= i_cfg_data[TICKS_W-1:0];
                    CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                    CFG_GRAV:  r_grav  <= i_cfg_data[GRAV_W-1:0];
                    CFG_TOL:   r_tol   <= i_cfg_data[TOL_W-1:0];
                    CFG_GYRO:  r_gyro  <= i_cfg_data[GYRO_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_MUL;
                        r_step  <= ST_AXX;
                    end
                end
                S_MUL: begin
                    if (r_step == ST_C2Y) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_step <= t_step'(r_step + 5'd1);
                    end
                end
                S_WAIT: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    // a nudge of an existing bias needs one more product
                    if (dec_update && r_bias_vld) begin
                        r_step  <= ST_NUDGE;
                        r_state <= S_NMUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                    if (dec_still) begin
                        r_cnt <= cnt_inc;
                        if (dec_update) begin
                            r_nudged <= 1'b1;
                            if (!r_bias_vld) begin
                                // very first estimate is taken outright
                                r_bias     <= dec_s;
                                r_bias_vld <= 1'b1;
                            end
                        end
                    end else begin
                        r_cnt    <= '0;
                        r_nudged <= 1'b0;
                    end
                end
                S_NMUL: begin
                    r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    r_state <= S_NADD;
                end
                S_NADD: begin
                    r_bias  <= n_bias;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath: item capture, multiplier register, accumulators, output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ax <= i_in.accel_x;
            r_ay <= i_in.accel_y;
            r_az <= i_in.accel_z;
            r_gx <= i_in.rate_x;
            r_gy <= i_in.rate_y;
            r_gz <= i_in.rate_z;
            r_qw <= i_in.quat_w;
            r_qx <= i_in.quat_x;
            r_qy <= i_in.quat_y;
            r_qz <= i_in.quat_z;
        end

        if (issue) begin
            r_prod  <= mul_p;
            r_pstep <= r_step;
        end

        // retire the product issued last cycle
        if (r_pvld) begin
            case (r_pstep)
                ST_AXX:   r_am <= r_prod[MAG_W-1:0];
                ST_AYY:   r_am <= r_am + r_prod[MAG_W-1:0];
                ST_AZZ:   r_am <= r_am + r_prod[MAG_W-1:0];
                ST_GXX:   r_gm <= r_prod[MAG_W-1:0];
                ST_GYY:   r_gm <= r_gm + r_prod[MAG_W-1:0];
                ST_GZZ:   r_gm <= r_gm + r_prod[MAG_W-1:0];
                // a negative lower bound passes by itself
                ST_LO:    r_lo_ok <= lim_lo[LIM_W-1] || (r_am > r_prod[MAG_W-1:0]);
                ST_HI:    r_hi_ok <= r_am < r_prod[MAG_W-1:0];
                ST_GYRO:  r_gy_ok <= r_gm < r_prod[MAG_W-1:0];
                ST_QWW:   r_c0 <= $signed(r_prod[COEF_W-1:0]);
                ST_QXX:   r_c0 <= r_c0 - $signed(r_prod[COEF_W-1:0]);
                ST_QYY:   r_c0 <= r_c0 - $signed(r_prod[COEF_W-1:0]);
                ST_QZZ:   r_c0 <= r_c0 + $signed(r_prod[COEF_W-1:0]);
                ST_QWX:   r_c1 <= $signed(r_prod[COEF_W-1:0]);
                ST_QYZ:   r_c1 <= r_c1 + $signed(r_prod[COEF_W-1:0]);
                ST_QWY:   r_c2 <= $signed(r_prod[COEF_W-1:0]);
                ST_QXZ:   r_c2 <= r_c2 - $signed(r_prod[COEF_W-1:0]);
                ST_C0Z:   r_earth <= $signed(r_prod[EARTH_W-1:0]);
                ST_C1X:   r_earth <= r_earth + $signed(r_prod[EARTH_W-1:0]);
                ST_C2Y:   r_earth <= r_earth + $signed(r_prod[EARTH_W-1:0]);
                ST_NUDGE: r_nudge <= $signed(r_prod[NUDGE_W-1:0]);
                default: ;
            endcase
        end

        if (r_state == S_ROUND) begin
            r_sample <= n_sample;
        end

        if (r_state == S_DECIDE) begin
            r_vert  <= dec_vert;
            r_d     <= dec_d;
            r_still <= dec_still;
        end

        if (out_load) begin
            r_o_vert  <= r_vert;
            r_o_bias  <= r_bias;
            r_o_bvld  <= r_bias_vld;
            r_o_still <= r_still;
        end
    end

    // an accepted item always starts the multiplier sequence at its first step
    `SGABT_ASSERT_NEXT(a_seq_start, i_clk, i_rst_n, in_acc, r_state == S_MUL && r_step == ST_AXX, "item accepted without sequence start")

    // a product is only in flight right after an issue cycle
    `SGABT_ASSERT_NOW(a_prod_window, i_clk, i_rst_n, r_pvld, r_state == S_MUL || r_state == S_WAIT || r_state == S_NWAIT, "product pending outside issue window")

    // once taken, the bias stays valid until reset
    `SGABT_ASSERT_NEXT(a_bias_sticky, i_clk, i_rst_n, r_bias_vld, r_bias_vld, "bias valid dropped")

    // a nudged period implies a nonzero still count
    `SGABT_ASSERT_NOW(a_nudge_count, i_clk, i_rst_n, r_nudged, r_cnt != '0, "period marked nudged with zero still count")

endmodule
